>>> design/lru_pkg.sv
// Shared types and constants for the LRU page replacement block.
package lru_pkg;

  localparam int unsigned MAX_FRAMES_DEF = 64;
  localparam int unsigned QUEUE_DEPTH    = 2;

  localparam int unsigned ADDR_W    = 32;
  localparam int unsigned FRAME_W   = 6;
  localparam int unsigned TOTAL_W   = 32;
  localparam int unsigned TICK_W    = 64;
  localparam int unsigned FIU_W     = 7;
  localparam int unsigned DIV_STEPS = 32;
  localparam int unsigned STEP_W    = $clog2(DIV_STEPS);

  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_FRAMES_IN_USE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_PAGE_SIZE     = 1'b1;

  localparam logic [FIU_W-1:0]  FRAMES_RST    = 7'd64;
  localparam logic [ADDR_W-1:0] PAGE_SIZE_RST = 32'd4096;

  typedef struct packed {
    logic               fault;
    logic [FRAME_W-1:0] frame;
    logic [TOTAL_W-1:0] fault_total;
    logic [TOTAL_W-1:0] reference_total;
  } result_t;

endpackage

>>> design/lru_page_replacement.sv
// Path: a bit-serial divider turns each accepted address into a page number, which a queue
//   hands to the frame scan (one memory read a cycle); results wait in a result queue.
//   The front can divide a new address while the back still scans the previous one.
// Reset (rst, synchronous): queues emptied, tick, totals and fill count zeroed,
//   frames_in_use = 64, page_size = 4096. Frame memories are not cleared.
module lru_page_replacement #(
  parameter int unsigned MAX_FRAMES = lru_pkg::MAX_FRAMES_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           push,
  output logic                           full,
  input  logic [lru_pkg::ADDR_W-1:0]     address,
  output logic                           empty,
  input  logic                           pop,
  output logic                           fault,
  output logic [lru_pkg::FRAME_W-1:0]    frame,
  output logic [lru_pkg::TOTAL_W-1:0]    fault_total,
  output logic [lru_pkg::TOTAL_W-1:0]    reference_total,
  input  logic                           write_enable,
  input  logic [lru_pkg::CFG_IDX_W-1:0]  reg_index,
  input  logic [lru_pkg::CFG_DATA_W-1:0] write_data
);
  import lru_pkg::*;

  logic [FIU_W-1:0]  frames_in_use;
  logic [ADDR_W-1:0] page_size;
  logic              mid_push;
  logic [ADDR_W-1:0] mid_wdata;
  logic              mid_full;
  logic              mid_pop;
  logic [ADDR_W-1:0] mid_rdata;
  logic              mid_empty;
  logic              res_push;
  logic              res_full;
  result_t           res_in;
  result_t           res_out;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      frames_in_use <= FRAMES_RST;
      page_size     <= PAGE_SIZE_RST;
    end else if (write_enable) begin
      unique case (reg_index)
        REG_FRAMES_IN_USE: frames_in_use <= write_data[FIU_W-1:0];
        REG_PAGE_SIZE:     page_size     <= write_data[ADDR_W-1:0];
        default: ;
      endcase
    end
  end

  lru_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .address   (address),
    .page_size (page_size),
    .q_push    (mid_push),
    .q_data    (mid_wdata),
    .q_full    (mid_full)
  );

  lru_fifo #(
    .WIDTH (ADDR_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_mid_q (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (mid_push),
    .wr_data (mid_wdata),
    .full    (mid_full),
    .rd_en   (mid_pop),
    .rd_data (mid_rdata),
    .empty   (mid_empty)
  );

  lru_back #(
    .MAX_FRAMES (MAX_FRAMES)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .frames_in_use (frames_in_use),
    .q_empty       (mid_empty),
    .q_data        (mid_rdata),
    .q_pop         (mid_pop),
    .res_full      (res_full),
    .res_push      (res_push),
    .res           (res_in)
  );

  lru_fifo #(
    .WIDTH ($bits(result_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_res_q (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (res_push),
    .wr_data (res_in),
    .full    (res_full),
    .rd_en   (pop),
    .rd_data (res_out),
    .empty   (empty)
  );

  assign fault           = res_out.fault;
  assign frame           = res_out.frame;
  assign fault_total     = res_out.fault_total;
  assign reference_total = res_out.reference_total;

  // Accepted beat makes the front busy until its page number is queued
  a_front_busy: assert property (@(posedge clk) disable iff (rst)
    (push && !full) |=> full)
    else $error("front took a beat but did not go busy");

  // Front never pushes into a full middle queue
  a_mid_no_overflow: assert property (@(posedge clk) disable iff (rst)
    mid_push |-> !mid_full)
    else $error("middle queue overflow");

  // Back never pushes into a full result queue
  a_res_no_overflow: assert property (@(posedge clk) disable iff (rst)
    res_push |-> !res_full)
    else $error("result queue overflow");

  // A result push is followed by the back pushing no result the next cycle
  a_res_single: assert property (@(posedge clk) disable iff (rst)
    res_push |=> !res_push)
    else $error("back produced two results back to back");

endmodule

>>> design/lru_fifo.sv
// Small synchronous queue used between the front, back and result side.
module lru_fifo #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);
  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] store [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_wr;
  logic             do_rd;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = store[rd_ptr];

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

  // Hold entry data
  always_ff @(posedge clk) begin
    if (do_wr) begin
      store[wr_ptr] <= wr_data;
    end
  end

endmodule

>>> design/lru_front.sv
// Front end: accept an address and divide it by the page size, one bit a cycle.
module lru_front (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  output logic                       full,
  input  logic [lru_pkg::ADDR_W-1:0] address,
  input  logic [lru_pkg::ADDR_W-1:0] page_size,
  output logic                       q_push,
  output logic [lru_pkg::ADDR_W-1:0] q_data,
  input  logic                       q_full
);
  import lru_pkg::*;

  typedef enum logic [2:0] {
    F_IDLE = 3'b001,
    F_DIV  = 3'b010,
    F_PUSH = 3'b100
  } front_state_t;

  front_state_t      state;
  logic [STEP_W-1:0] step;
  logic [ADDR_W-1:0] quo;
  logic [ADDR_W-1:0] rem;
  logic [ADDR_W-1:0] divisor;
  logic [ADDR_W:0]   trial;
  logic [ADDR_W:0]   diff;
  logic              qbit;
  logic [ADDR_W-1:0] rem_next;

  assign full   = (state != F_IDLE);
  assign q_push = (state == F_PUSH) && !q_full;
  assign q_data = quo;

  // One restoring division step
  always_comb begin
    trial    = {rem, quo[ADDR_W-1]};
    diff     = trial - {1'b0, divisor};
    qbit     = !diff[ADDR_W];
    rem_next = qbit ? diff[ADDR_W-1:0] : trial[ADDR_W-1:0];
  end

  // Sequence accept, divide, hand off
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      unique case (state)
        F_IDLE: begin
          if (push) begin
            state <= F_DIV;
          end
        end
        F_DIV: begin
          if (step == STEP_W'(DIV_STEPS - 1)) begin
            state <= F_PUSH;
          end
        end
        F_PUSH: begin
          if (!q_full) begin
            state <= F_IDLE;
          end
        end
        default: state <= F_IDLE;
      endcase
    end
  end

  // Divider datapath; a zero page size divides by one
  always_ff @(posedge clk) begin
    if (state == F_IDLE) begin
      quo     <= address;
      rem     <= '0;
      step    <= '0;
      divisor <= (page_size == '0) ? ADDR_W'(1) : page_size;
    end else if (state == F_DIV) begin
      quo  <= {quo[ADDR_W-2:0], qbit};
      rem  <= rem_next;
      step <= step + 1'b1;
    end
  end

endmodule

>>> design/lru_back.sv
// Back end: scan resident frames for a hit and the oldest frame, then update.
module lru_back #(
  parameter int unsigned MAX_FRAMES = lru_pkg::MAX_FRAMES_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [lru_pkg::FIU_W-1:0]  frames_in_use,
  input  logic                       q_empty,
  input  logic [lru_pkg::ADDR_W-1:0] q_data,
  output logic                       q_pop,
  input  logic                       res_full,
  output logic                       res_push,
  output lru_pkg::result_t           res
);
  import lru_pkg::*;

  localparam int unsigned FW    = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_FRAMES + 1);
  localparam int unsigned LIM_W = (CNT_W > FIU_W) ? CNT_W : FIU_W;
  localparam int unsigned EXT_W = FW + FRAME_W;

  typedef enum logic [2:0] {
    B_IDLE = 3'b001,
    B_SCAN = 3'b010,
    B_DONE = 3'b100
  } back_state_t;

  back_state_t        state;
  logic [ADDR_W-1:0]  page_mem [MAX_FRAMES];
  logic [TICK_W-1:0]  tick_mem [MAX_FRAMES];
  logic [ADDR_W-1:0]  rd_page;
  logic [TICK_W-1:0]  rd_tick;
  logic [CNT_W-1:0]   rd_idx;
  logic               cmp_v;
  logic [FW-1:0]      cmp_idx;
  logic [ADDR_W-1:0]  page_r;
  logic               hit_found;
  logic [FW-1:0]      hit_idx;
  logic [FW-1:0]      min_idx;
  logic [TICK_W-1:0]  min_tick;
  logic [CNT_W-1:0]   filled;
  logic [TICK_W-1:0]  tick;
  logic [TOTAL_W-1:0] faults;
  logic [TOTAL_W-1:0] refs;
  logic [TOTAL_W-1:0] faults_next;
  logic [TOTAL_W-1:0] refs_next;
  logic [LIM_W-1:0]   lim;
  logic               issue;
  logic               fill;
  logic [FW-1:0]      frame_sel;
  logic [EXT_W-1:0]   frame_ext;

  // Clamp the frame limit to one..MAX_FRAMES
  always_comb begin
    if (frames_in_use == '0) begin
      lim = LIM_W'(1);
    end else if (LIM_W'(frames_in_use) > LIM_W'(MAX_FRAMES)) begin
      lim = LIM_W'(MAX_FRAMES);
    end else begin
      lim = LIM_W'(frames_in_use);
    end
  end

  // Pick the frame to hit, fill or replace
  always_comb begin
    issue       = (rd_idx != filled);
    fill        = !hit_found && (LIM_W'(filled) < lim);
    frame_sel   = hit_found ? hit_idx : (fill ? filled[FW-1:0] : min_idx);
    frame_ext   = EXT_W'(frame_sel);
    faults_next = (!hit_found && (faults != '1)) ? faults + 1'b1 : faults;
    refs_next   = (refs != '1) ? refs + 1'b1 : refs;
  end

  assign q_pop    = (state == B_IDLE) && !q_empty;
  assign res_push = (state == B_DONE) && !res_full;

  always_comb begin
    res.fault           = !hit_found;
    res.frame           = frame_ext[FRAME_W-1:0];
    res.fault_total     = faults_next;
    res.reference_total = refs_next;
  end

  // Sequence and architectural state
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= B_IDLE;
      cmp_v  <= 1'b0;
      filled <= '0;
      tick   <= '0;
      faults <= '0;
      refs   <= '0;
    end else begin
      cmp_v <= (state == B_SCAN) && issue;
      unique case (state)
        B_IDLE: begin
          if (!q_empty) begin
            state <= B_SCAN;
          end
        end
        B_SCAN: begin
          if (!issue && !cmp_v) begin
            state <= B_DONE;
          end
        end
        B_DONE: begin
          if (!res_full) begin
            state  <= B_IDLE;
            tick   <= tick + 1'b1;
            faults <= faults_next;
            refs   <= refs_next;
            if (fill) begin
              filled <= filled + 1'b1;
            end
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

  // Scan datapath: issue reads, compare registered data
  always_ff @(posedge clk) begin
    if (state == B_IDLE) begin
      page_r    <= q_data;
      hit_found <= 1'b0;
      rd_idx    <= '0;
      min_idx   <= '0;
    end else if (state == B_SCAN) begin
      if (issue) begin
        rd_idx <= rd_idx + 1'b1;
      end
      cmp_idx <= rd_idx[FW-1:0];
      if (cmp_v) begin
        if (!hit_found && (rd_page == page_r)) begin
          hit_found <= 1'b1;
          hit_idx   <= cmp_idx;
        end
        if ((cmp_idx == '0) || (rd_tick < min_tick)) begin
          min_tick <= rd_tick;
          min_idx  <= cmp_idx;
        end
      end
    end
  end

  // Frame memories: one read, one write a cycle
  always_ff @(posedge clk) begin
    if (state == B_SCAN) begin
      rd_page <= page_mem[rd_idx[FW-1:0]];
      rd_tick <= tick_mem[rd_idx[FW-1:0]];
    end
    if (res_push) begin
      tick_mem[frame_sel] <= tick;
      if (!hit_found) begin
        page_mem[frame_sel] <= page_r;
      end
    end
  end

endmodule

>>> bench/tb.sv
// Self-checking bench for the LRU page replacement block: directed and random traces.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import lru_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 1_000_000;
  localparam int unsigned PHASES        = 9;
  localparam int unsigned REFS_PER_PASS = 56;
  localparam int unsigned PRINT_CAP     = 40;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  push = 1'b0;
  logic                  full;
  logic [ADDR_W-1:0]     address = '0;
  logic                  empty;
  logic                  pop = 1'b0;
  logic                  fault;
  logic [FRAME_W-1:0]    frame;
  logic [TOTAL_W-1:0]    fault_total;
  logic [TOTAL_W-1:0]    reference_total;
  logic                  write_enable = 1'b0;
  logic [CFG_IDX_W-1:0]  reg_index = REG_FRAMES_IN_USE;
  logic [CFG_DATA_W-1:0] write_data = '0;

  // Shadow of the block: configuration, frame table, tick and totals
  logic [FIU_W-1:0]   cfg_frames    = FRAMES_RST;
  logic [ADDR_W-1:0]  cfg_page_size = PAGE_SIZE_RST;
  logic [ADDR_W-1:0]  frame_page [MAX_FRAMES_DEF];
  logic [TICK_W-1:0]  frame_stamp [MAX_FRAMES_DEF];
  int unsigned        fill_level   = 0;
  logic [TICK_W-1:0]  tick_count   = '0;
  logic [TOTAL_W-1:0] faults_total = '0;
  logic [TOTAL_W-1:0] refs_total   = '0;

  logic [ADDR_W-1:0] trace_queue[$];
  result_t           outcome_queue[$];
  result_t           head;
  int unsigned       queued_count   = 0;
  int unsigned       checked_count  = 0;
  int unsigned       mismatch_count = 0;
  int unsigned       cycle_count    = 0;
  int unsigned       send_idle_pct  = 0;
  int unsigned       recv_idle_pct  = 0;

  lru_page_replacement dut (
    .clk             (clk),
    .rst             (rst),
    .push            (push),
    .full            (full),
    .address         (address),
    .empty           (empty),
    .pop             (pop),
    .fault           (fault),
    .frame           (frame),
    .fault_total     (fault_total),
    .reference_total (reference_total),
    .write_enable    (write_enable),
    .reg_index       (reg_index),
    .write_data      (write_data)
  );

  always #10 clk = ~clk;

  // Look up one reference, update the shadow table and return its outcome
  function automatic result_t replace_lookup(logic [ADDR_W-1:0] addr);
    logic [ADDR_W-1:0] divisor;
    logic [ADDR_W-1:0] page_num;
    int unsigned       limit;
    int unsigned       slot;
    int unsigned       i;
    bit                hit;
    result_t           res;
    divisor  = (cfg_page_size == '0) ? 32'd1 : cfg_page_size;
    page_num = addr / divisor;
    if (cfg_frames == '0) limit = 1;
    else if (cfg_frames > MAX_FRAMES_DEF) limit = MAX_FRAMES_DEF;
    else limit = cfg_frames;
    if (refs_total != '1) refs_total++;
    hit  = 1'b0;
    slot = 0;
    for (i = 0; i < fill_level; i++) begin
      if (!hit && frame_page[i] == page_num) begin
        hit  = 1'b1;
        slot = i;
      end
    end
    if (!hit) begin
      if (faults_total != '1) faults_total++;
      if (fill_level < limit) begin
        slot = fill_level;
        fill_level++;
      end else begin
        // Oldest stamp among all filled frames; strict compare keeps the lowest index
        slot = 0;
        for (i = 1; i < fill_level; i++)
          if (frame_stamp[i] < frame_stamp[slot]) slot = i;
      end
      frame_page[slot] = page_num;
    end
    frame_stamp[slot]   = tick_count;
    tick_count++;
    res.fault           = !hit;
    res.frame           = slot[FRAME_W-1:0];
    res.fault_total     = faults_total;
    res.reference_total = refs_total;
    return res;
  endfunction

  // Pick an address in a window of pages starting at first_page
  function automatic logic [ADDR_W-1:0] working_set_addr(longint unsigned first_page,
                                                        int unsigned span);
    longint unsigned divisor;
    longint unsigned max_page;
    longint unsigned pg;
    longint unsigned lo;
    longint unsigned room;
    divisor  = (cfg_page_size == '0) ? 1 : cfg_page_size;
    max_page = 64'hFFFF_FFFF / divisor;
    pg       = first_page + $urandom_range(0, span - 1);
    if (pg > max_page) pg = max_page;
    lo   = pg * divisor;
    room = 64'hFFFF_FFFF - lo;
    if (room > divisor - 1) room = divisor - 1;
    return ADDR_W'(lo + ({$urandom, $urandom} % (room + 1)));
  endfunction

  task automatic flag_mismatch(string msg);
    if (mismatch_count < PRINT_CAP) $display("[%0t] MISMATCH: %s", $realtime, msg);
    mismatch_count++;
  endtask

  task automatic queue_ref(logic [ADDR_W-1:0] addr);
    trace_queue.push_back(addr);
    queued_count++;
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    @(posedge clk);
    write_enable <= 1'b1;
    reg_index    <= idx;
    write_data   <= value;
    @(posedge clk);
    write_enable <= 1'b0;
    if (idx == REG_FRAMES_IN_USE) cfg_frames = value[FIU_W-1:0];
    else cfg_page_size = value;
  endtask

  // Hold until every queued reference has come back, then let the pipe settle
  task automatic wait_drained();
    while (checked_count != queued_count) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Driver: present one address per beat, hold it while the block is full
  always @(posedge clk) begin
    if (rst) begin
      push <= 1'b0;
    end else begin
      if (push && !full) outcome_queue.push_back(replace_lookup(address));
      if (!push || !full) begin
        if (trace_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          push    <= 1'b1;
          address <= trace_queue.pop_front();
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // Monitor: take result beats and compare them with the oldest outcome
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (outcome_queue.size() == 0) begin
          flag_mismatch($sformatf("result with none awaited: fault=%0b frame=%0d",
                                  fault, frame));
        end else begin
          head = outcome_queue.pop_front();
          if (fault !== head.fault)
            flag_mismatch($sformatf("fault got %0b want %0b", fault, head.fault));
          if (frame !== head.frame)
            flag_mismatch($sformatf("frame got %0d want %0d", frame, head.frame));
          if (fault_total !== head.fault_total)
            flag_mismatch($sformatf("fault_total got %0d want %0d",
                                    fault_total, head.fault_total));
          if (reference_total !== head.reference_total)
            flag_mismatch($sformatf("reference_total got %0d want %0d",
                                    reference_total, head.reference_total));
          checked_count++;
        end
      end
      pop <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    int unsigned       frames_plan [PHASES];
    logic [ADDR_W-1:0] psize_plan [PHASES];
    longint unsigned   divisor;
    longint unsigned   max_page;
    longint unsigned   first_page;
    int unsigned       span;
    int unsigned       eff;
    frames_plan = '{4, 8, 1, 16, 32, 20, 64, 127, 2};
    psize_plan  = '{32'd64, 32'd4096, 32'd1, 32'd256, 32'h8000_0000, 32'd0,
                    32'd4096, 32'hFFFF_FFFF, 32'd0};
    psize_plan[5] = $urandom_range(3, 99999);

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    send_idle_pct = 25;
    recv_idle_pct = 50;

    // Reset settings: extreme addresses, a hit within one page, the top page
    queue_ref(32'h0000_0000);
    queue_ref(32'hFFFF_FFFF);
    queue_ref(32'h0000_0FFF);
    queue_ref(32'h0000_1000);
    queue_ref(32'hFFFF_F000);
    wait_drained();

    // Zero frame count acts as one frame, zero page size as one
    write_reg(REG_FRAMES_IN_USE, 32'd0);
    write_reg(REG_PAGE_SIZE, 32'd0);
    queue_ref(32'h0000_0000);
    queue_ref(32'hFFFF_FFFF);
    queue_ref(32'hFFFF_FFFF);
    queue_ref(32'h5555_5555);
    wait_drained();

    // Page size 0x8000_0000; old page numbers stay as stored
    write_reg(REG_FRAMES_IN_USE, 32'd3);
    write_reg(REG_PAGE_SIZE, 32'h8000_0000);
    queue_ref(32'h0000_0000);
    queue_ref(32'h7FFF_FFFF);
    queue_ref(32'h8000_0000);
    queue_ref(32'hAAAA_AAAA);
    wait_drained();

    // Frame count above the maximum saturates; widest page size
    write_reg(REG_FRAMES_IN_USE, 32'd127);
    write_reg(REG_PAGE_SIZE, 32'hFFFF_FFFF);
    queue_ref(32'hFFFF_FFFE);
    queue_ref(32'hFFFF_FFFF);
    queue_ref(32'h1234_5678);
    wait_drained();

    // Frame count below the filled count: misses replace among all filled frames
    write_reg(REG_FRAMES_IN_USE, 32'd1);
    write_reg(REG_PAGE_SIZE, 32'd1);
    queue_ref(32'h0000_0002);
    queue_ref(32'h0000_0003);
    queue_ref(32'h0000_0002);
    queue_ref(32'h0000_0004);

    // Random passes: mostly a working set near the frame count, some full-range noise
    for (int p = 0; p < PHASES; p++) begin
      wait_drained();
      if (p < 3) begin
        send_idle_pct = 25;
        recv_idle_pct = 50;
      end else if (p < 6) begin
        send_idle_pct = 50;
        recv_idle_pct = 25;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      write_reg(REG_FRAMES_IN_USE, frames_plan[p]);
      write_reg(REG_PAGE_SIZE, psize_plan[p]);
      eff      = (cfg_frames == '0) ? 1 :
                 (cfg_frames > MAX_FRAMES_DEF) ? MAX_FRAMES_DEF : cfg_frames;
      span     = eff + eff / 2 + 1;
      divisor  = (cfg_page_size == '0) ? 1 : cfg_page_size;
      max_page = 64'hFFFF_FFFF / divisor;
      if (max_page + 1 > span) first_page = {$urandom} % (max_page + 2 - span);
      else first_page = 0;
      repeat (REFS_PER_PASS) begin
        if ($urandom_range(0, 99) < 15) queue_ref($urandom);
        else queue_ref(working_set_addr(first_page, span));
      end
    end

    wait_drained();
    repeat (120) @(posedge clk);
    if (outcome_queue.size() != 0)
      flag_mismatch($sformatf("%0d results never arrived", outcome_queue.size()));
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
